// ===== hw/rtl/rptw_pkg.sv =====
package rptw_pkg;

  localparam int unsigned FRAMES      = 64;
  localparam int unsigned LEVEL_COUNT = 5;
  localparam int unsigned INDEX_BITS  = 9;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PPN_W      = 52;
  localparam int unsigned VPN_W      = 45;
  localparam int unsigned PTE_W      = 64;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;

  localparam int unsigned ENTRIES = 1 << INDEX_BITS;
  localparam int unsigned DEPTH   = FRAMES * ENTRIES;
  localparam int unsigned FRAME_W = (FRAMES > 2) ? $clog2(FRAMES) : 1;
  localparam int unsigned ADDR_W  = FRAME_W + INDEX_BITS;
  localparam int unsigned USED_W  = LEVEL_COUNT * INDEX_BITS;
  localparam int unsigned LVL_W   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int unsigned NF_MAX  = (FRAMES > 63) ? FRAMES : 63;
  localparam int unsigned NF_W    = $clog2(NF_MAX + 1);

  localparam logic CFG_ROOT_FRAME = 1'b0;
  localparam logic CFG_FIRST_FREE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY = 2'd0,
    MODE_MAP   = 2'd1,
    MODE_UNMAP = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FRAME = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [CFG_W-1:0] root_frame;
    logic             nf_load;
    logic [CFG_W-1:0] nf_value;
  } cfg_t;

  typedef struct packed {
    logic [PPN_W-1:0] ppn_out;
    logic             mapped;
    status_e          status;
  } res_t;

endpackage

// ===== hw/rtl/rptw_frame_mem.sv =====
module rptw_frame_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [rptw_pkg::ADDR_W-1:0]   addr_i,
  input  logic [rptw_pkg::PTE_W-1:0]    wdata_i,
  output logic [rptw_pkg::PTE_W-1:0]    rdata_o
);

  logic [rptw_pkg::PTE_W-1:0] mem [rptw_pkg::DEPTH];
  logic [rptw_pkg::PTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rptw_walker.sv =====
module rptw_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rptw_pkg::cfg_t                cfg_i,
  input  logic                          start_i,
  output logic                          ready_o,
  input  logic [rptw_pkg::MODE_W-1:0]   mode_i,
  input  logic [rptw_pkg::VPN_W-1:0]    vpn_i,
  input  logic [rptw_pkg::PPN_W-1:0]    ppn_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output rptw_pkg::res_t                res_o,
  output logic                          mem_we_o,
  output logic [rptw_pkg::ADDR_W-1:0]   mem_addr_o,
  output logic [rptw_pkg::PTE_W-1:0]    mem_wdata_o,
  input  logic [rptw_pkg::PTE_W-1:0]    mem_rdata_i
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  localparam logic [rptw_pkg::LVL_W-1:0]  LAST_LEVEL =
    rptw_pkg::LVL_W'(rptw_pkg::LEVEL_COUNT - 1);
  localparam logic [rptw_pkg::ADDR_W-1:0] LAST_ADDR =
    rptw_pkg::ADDR_W'(rptw_pkg::DEPTH - 1);
  localparam logic [rptw_pkg::NF_W-1:0]   NF_LIMIT = rptw_pkg::NF_W'(rptw_pkg::FRAMES);
  localparam logic [rptw_pkg::PPN_W-1:0]  PTR_LIMIT = rptw_pkg::PPN_W'(rptw_pkg::FRAMES);
  localparam int unsigned LOW_W = rptw_pkg::PAGE_SHIFT - 1;

  state_e                          state_q, state_d;
  logic [rptw_pkg::ADDR_W-1:0]     clr_q, clr_d;
  logic [rptw_pkg::NF_W-1:0]       nf_q, nf_d;
  rptw_pkg::mode_e                 mode_q, mode_d;
  logic [rptw_pkg::VPN_W-1:0]      vpn_q, vpn_d;
  logic [rptw_pkg::PPN_W-1:0]      ppn_q, ppn_d;
  logic [rptw_pkg::FRAME_W-1:0]    frame_q, frame_d;
  logic [rptw_pkg::LVL_W-1:0]      level_q, level_d;
  rptw_pkg::res_t                  res_q, res_d;

  logic [rptw_pkg::ADDR_W-1:0]     cur_addr;
  logic [rptw_pkg::PPN_W-1:0]      pte_ptr;
  logic                            last_level;
  logic                            root_bad;

  assign cur_addr   = {frame_q, vpn_q[rptw_pkg::USED_W-1 -: rptw_pkg::INDEX_BITS]};
  assign pte_ptr    = mem_rdata_i[rptw_pkg::PTE_W-1:rptw_pkg::PAGE_SHIFT];
  assign last_level = (level_q == LAST_LEVEL);
  assign root_bad   = (rptw_pkg::PPN_W'(cfg_i.root_frame) >= PTR_LIMIT);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    nf_d        = nf_q;
    mode_d      = mode_q;
    vpn_d       = vpn_q;
    ppn_d       = ppn_q;
    frame_d     = frame_q;
    level_d     = level_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = cur_addr;
    mem_wdata_o = '0;

    if (cfg_i.nf_load) begin
      nf_d = rptw_pkg::NF_W'(cfg_i.nf_value);
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          mode_d  = rptw_pkg::mode_e'(mode_i);
          vpn_d   = vpn_i;
          ppn_d   = ppn_i;
          frame_d = rptw_pkg::FRAME_W'(cfg_i.root_frame);
          level_d = '0;
          res_d   = '0;
          case (mode_i)
            rptw_pkg::MODE_QUERY, rptw_pkg::MODE_MAP, rptw_pkg::MODE_UNMAP: begin
              if (root_bad) begin
                res_d.status = rptw_pkg::STATUS_RANGE;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_READ;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_READ: begin
        if (mode_q != rptw_pkg::MODE_QUERY && last_level) begin
          mem_we_o = 1'b1;
          if (mode_q == rptw_pkg::MODE_MAP) begin
            mem_wdata_o = {ppn_q, {LOW_W{1'b0}}, 1'b1};
          end
          state_d = ST_RESP;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_RESP;
        if (mode_q == rptw_pkg::MODE_QUERY) begin
          if (mem_rdata_i[0]) begin
            if (last_level) begin
              res_d.ppn_out = pte_ptr;
              res_d.mapped  = 1'b1;
            end else if (pte_ptr >= PTR_LIMIT) begin
              res_d.status = rptw_pkg::STATUS_RANGE;
            end else begin
              frame_d = pte_ptr[rptw_pkg::FRAME_W-1:0];
              level_d = level_q + 1'b1;
              vpn_d   = vpn_q << rptw_pkg::INDEX_BITS;
              state_d = ST_READ;
            end
          end
        end else if (!mem_rdata_i[0]) begin
          if (nf_q >= NF_LIMIT) begin
            res_d.status = rptw_pkg::STATUS_NO_FRAME;
          end else begin
            mem_we_o    = 1'b1;
            mem_wdata_o = {rptw_pkg::PPN_W'(nf_q), {LOW_W{1'b0}}, 1'b1};
            nf_d        = nf_q + 1'b1;
            frame_d     = rptw_pkg::FRAME_W'(nf_q);
            level_d     = level_q + 1'b1;
            vpn_d       = vpn_q << rptw_pkg::INDEX_BITS;
            state_d     = ST_READ;
          end
        end else if (pte_ptr >= PTR_LIMIT) begin
          res_d.status = rptw_pkg::STATUS_RANGE;
        end else begin
          frame_d = pte_ptr[rptw_pkg::FRAME_W-1:0];
          level_d = level_q + 1'b1;
          vpn_d   = vpn_q << rptw_pkg::INDEX_BITS;
          state_d = ST_READ;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      nf_q    <= rptw_pkg::NF_W'(1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nf_q    <= nf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    vpn_q   <= vpn_d;
    ppn_q   <= ppn_d;
    frame_q <= frame_d;
    level_q <= level_d;
    res_q   <= res_d;
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/radix_page_table_walker_unit.sv =====
// channel   direction  tdata fields, lowest bit first
// s_axis    in         mode[1:0], vpn[46:2], ppn[98:47], zero fill to 104 bits
// m_axis    out        ppn_out[51:0], mapped[52], status[54:53], zero fill to 56 bits
// cfg       in         cfg_idx_i 0 root_frame, 1 first_free_frame; cfg_data_i 6 bits
//
// after reset the frame memory is cleared one entry a cycle, with s_axis_tready_o low;
// config writes are taken during that pass.
// one item at a time: an accept state, then per table level a memory read and a check
// through the single memory port (at the last map/unmap level, one leaf write instead),
// then a result state that waits until the output register can take the result.
// a finished result sits in the output register; the next item is taken meanwhile.
module radix_page_table_walker_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rptw_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [103:0]               s_axis_tdata_i,  // mode, vpn, ppn
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [55:0]                m_axis_tdata_o   // ppn_out, mapped, status
);

  logic [rptw_pkg::CFG_W-1:0]  root_q;
  rptw_pkg::cfg_t              cfg;
  logic                        start;
  logic                        walk_ready;
  logic                        res_valid;
  logic                        res_ready;
  rptw_pkg::res_t              res;
  logic                        out_valid_q;
  logic [55:0]                 out_data_q;
  logic                        mem_we;
  logic [rptw_pkg::ADDR_W-1:0] mem_addr;
  logic [rptw_pkg::PTE_W-1:0]  mem_wdata;
  logic [rptw_pkg::PTE_W-1:0]  mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == rptw_pkg::CFG_ROOT_FRAME) begin
      root_q <= cfg_data_i;
    end
  end

  assign cfg.root_frame = root_q;
  assign cfg.nf_load    = cfg_we_i && (cfg_idx_i == rptw_pkg::CFG_FIRST_FREE);
  assign cfg.nf_value   = cfg_data_i;

  assign start           = s_axis_tvalid_i && walk_ready;
  assign s_axis_tready_o = walk_ready;
  assign res_ready       = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {1'b0, res.status, res.mapped, res.ppn_out};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  rptw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .ready_o     (walk_ready),
    .mode_i      (s_axis_tdata_i[1:0]),
    .vpn_i       (s_axis_tdata_i[46:2]),
    .ppn_i       (s_axis_tdata_i[98:47]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  rptw_frame_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== dv/tb_radix_page_table_walker_unit.sv =====
`timescale 1ns / 1ps

module tb_radix_page_table_walker_unit;
  import rptw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned RAND_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned POOL_SIZE   = 16;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [VPN_W-1:0]  vpn;
    logic [PPN_W-1:0]  ppn;
  } walk_req_t;

  logic               clk_i;
  logic               rst_ni   = 1'b0;
  logic               cfg_we   = 1'b0;
  logic               cfg_idx  = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_valid  = 1'b0;
  logic               s_ready;
  logic [103:0]       s_data   = '0;
  logic               m_valid;
  logic               m_ready  = 1'b0;
  logic [55:0]        m_data;

  // model of the table and allocator
  logic [PTE_W-1:0]   pt_mem [DEPTH];
  int unsigned        root_q      = 0;
  int unsigned        next_free_q = 1;

  walk_req_t          pending_q [$];
  res_t               walk_res_q [$];
  walk_req_t          cur_req;
  res_t               want;
  logic [VPN_W-1:0]   vpn_pool [POOL_SIZE];
  int unsigned        tx_wait   = 0;
  int unsigned        rx_wait   = 0;
  int unsigned        n_results = 0;
  int unsigned        errors    = 0;
  int unsigned        cycles    = 0;
  bit                 no_idle   = 1'b0;

  radix_page_table_walker_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic res_t walk_table(walk_req_t rq);
    res_t                  r;
    logic [PTE_W-1:0]      pte;
    logic [PPN_W-1:0]      nxt;
    logic [INDEX_BITS-1:0] idx;
    int unsigned           frm;
    int unsigned           at;
    int                    lvl;
    bit                    done;
    r.ppn_out = '0;
    r.mapped  = 1'b0;
    r.status  = STATUS_OK;
    frm  = root_q;
    done = 1'b0;
    if (rq.mode == MODE_UNUSED) begin
      done = 1'b1;
    end else if (frm >= FRAMES) begin
      r.status = STATUS_RANGE;
      done = 1'b1;
    end
    for (lvl = 0; lvl < LEVEL_COUNT && !done; lvl++) begin
      idx = INDEX_BITS'(rq.vpn >> ((LEVEL_COUNT - 1 - lvl) * INDEX_BITS));
      at  = frm * ENTRIES + 32'(idx);
      pte = pt_mem[at];
      nxt = pte[PTE_W-1:PAGE_SHIFT];
      if (rq.mode == MODE_QUERY) begin
        if (!pte[0]) begin
          done = 1'b1;
        end else if (lvl == LEVEL_COUNT - 1) begin
          r.ppn_out = nxt;
          r.mapped  = 1'b1;
          done = 1'b1;
        end else if (nxt >= FRAMES) begin
          r.status = STATUS_RANGE;
          done = 1'b1;
        end else begin
          frm = 32'(nxt);
        end
      end else if (lvl == LEVEL_COUNT - 1) begin
        pt_mem[at] = (rq.mode == MODE_MAP) ? {rq.ppn, 12'h001} : '0;
        done = 1'b1;
      end else if (!pte[0]) begin
        if (next_free_q >= FRAMES) begin
          r.status = STATUS_NO_FRAME;
          done = 1'b1;
        end else begin
          pt_mem[at] = {PPN_W'(next_free_q), 12'h001};
          frm = next_free_q;
          next_free_q++;
        end
      end else if (nxt >= FRAMES) begin
        r.status = STATUS_RANGE;
        done = 1'b1;
      end else begin
        frm = 32'(nxt);
      end
    end
    return r;
  endfunction

  task automatic add_item(logic [MODE_W-1:0] md, logic [VPN_W-1:0] v, logic [PPN_W-1:0] p);
    walk_req_t rq;
    rq.mode = md;
    rq.vpn  = v;
    rq.ppn  = p;
    pending_q.push_back(rq);
  endtask

  // mostly vpns that share table frames with earlier ones, so the walk goes deep
  task automatic add_random_item();
    logic [VPN_W-1:0]  base;
    logic [VPN_W-1:0]  v;
    logic [PPN_W-1:0]  p;
    logic [MODE_W-1:0] md;
    int unsigned       sel;
    int unsigned       k;
    k    = $urandom_range(0, POOL_SIZE - 1);
    base = vpn_pool[k];
    v    = VPN_W'(rand64());
    sel  = $urandom_range(0, 99);
    if (sel < 45) begin
      v = base;
    end else if (sel < 75) begin
      v = {base[VPN_W-1:INDEX_BITS], v[INDEX_BITS-1:0]};
    end else if (sel < 92) begin
      v = {base[VPN_W-1:2*INDEX_BITS], v[2*INDEX_BITS-1:0]};
    end
    sel = $urandom_range(0, 99);
    if (sel < 40) md = MODE_MAP;
    else if (sel < 75) md = MODE_QUERY;
    else if (sel < 95) md = MODE_UNMAP;
    else md = MODE_UNUSED;
    p = ($urandom_range(0, 1) == 1) ? PPN_W'(rand64()) : PPN_W'($urandom_range(0, 63));
    if (md == MODE_MAP && $urandom_range(0, 3) == 0) vpn_pool[k] = v;
    add_item(md, v, p);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_valid || walk_res_q.size() != 0);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_ROOT_FRAME) begin
      root_q = val;
    end else begin
      next_free_q = val;
    end
  endtask

  task automatic write_config(logic [CFG_W-1:0] root, logic [CFG_W-1:0] first_free, bit fast);
    wait_idle();
    no_idle = fast;
    write_reg(CFG_ROOT_FRAME, root);
    write_reg(CFG_FIRST_FREE, first_free);
    @(negedge clk_i);
  endtask

  initial begin
    int i;
    int ph;
    for (i = 0; i < DEPTH; i++) pt_mem[i] = '0;
    for (i = 0; i < POOL_SIZE; i++) begin
      if (i < 4) vpn_pool[i] = VPN_W'(rand64());
      else vpn_pool[i] = {vpn_pool[i % 4][VPN_W-1:2*INDEX_BITS], 18'($urandom)};
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_config(6'd0, 6'd1, 1'b0);
    add_item(MODE_QUERY, '0, '0);
    add_item(MODE_MAP, '0, '0);
    add_item(MODE_QUERY, '0, '1);
    add_item(MODE_MAP, '1, '1);
    add_item(MODE_QUERY, '1, '0);
    add_item(MODE_UNMAP, '1, '1);
    add_item(MODE_QUERY, '1, '0);
    add_item(MODE_UNUSED, '1, '1);
    add_item(MODE_QUERY, '1, '0);
    add_item(MODE_UNMAP, 45'h0AAA_AAAA_AAAA, '0);
    add_item(MODE_MAP, 45'd1, 52'd1000);
    add_item(MODE_QUERY, 45'd1, '0);
    add_item(MODE_MAP, 45'h1555_5555_5555, 52'h5_5555_5555_5555);
    add_item(MODE_QUERY, 45'h1555_5555_5555, '0);

    // leaf frame as root: a valid entry pointing beyond memory
    write_config(6'd4, 6'd63, 1'b0);
    add_item(MODE_QUERY, 45'd1 << 36, '0);
    add_item(MODE_MAP, 45'd1 << 36, 52'd7);
    add_item(MODE_QUERY, '0, '0);

    // one frame left in the allocator
    write_config(6'd0, 6'd63, 1'b0);
    add_item(MODE_MAP, 45'd100 << 36, 52'd3);
    add_item(MODE_QUERY, 45'd100 << 36, '0);
    add_item(MODE_UNMAP, 45'd101 << 36, '0);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: write_config(6'd0, 6'd1, 1'b0);
        1: write_config(6'd63, 6'd0, 1'b0);
        2: write_config(6'd0, 6'd63, 1'b0);
        3: write_config(6'd1, 6'd2, 1'b1);
        default: write_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), 1'b0);
      endcase
      repeat (PHASE_ITEMS) add_random_item();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && walk_res_q.size() == 0) begin
      $display("tb_radix_page_table_walker_unit: done, clean");
    end else begin
      $display("tb_radix_page_table_walker_unit: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) walk_res_q.push_back(walk_table(cur_req));
      if (!s_valid || s_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur_req = pending_q.pop_front();
          s_data  <= {5'd0, cur_req.ppn, cur_req.vpn, cur_req.mode};
          s_valid <= 1'b1;
          tx_wait = no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        n_results++;
        if (walk_res_q.size() == 0) begin
          errors++;
          $display("%0t: item with nothing expected, actual %h", $time, m_data);
        end else begin
          want = walk_res_q.pop_front();
          if (m_data[51:0] !== want.ppn_out) begin
            errors++;
            $display("%0t: ppn_out expected %h actual %h", $time, want.ppn_out, m_data[51:0]);
          end
          if (m_data[52] !== want.mapped) begin
            errors++;
            $display("%0t: mapped expected %b actual %b", $time, want.mapped, m_data[52]);
          end
          if (m_data[54:53] !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, m_data[54:53]);
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 3);
        if (n_results == HOLD_AT) rx_wait = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_radix_page_table_walker_unit: done, errors");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/rptw_pkg.sv
hw/rtl/rptw_frame_mem.sv
hw/rtl/rptw_walker.sv
hw/rtl/radix_page_table_walker_unit.sv
dv/tb_radix_page_table_walker_unit.sv
